>>> sv/bam_pkg.sv
// Bitmap allocation map: shared widths, defaults and action codes.
// No dependencies; imported by bitmap_allocation_map.
package bam_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int MAP_WORDS_DEF = 32;

  localparam int ACT_W       = 3;
  localparam int POS_W       = 16;
  localparam int LEN_W       = 11;
  localparam int WIU_W       = 6;
  localparam int WIU_RESET   = 32;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;
  localparam int SCAN_LANES  = 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_SET  = 3'd0,
    ACT_CLR  = 3'd1,
    ACT_TEST = 3'd2,
    ACT_FFF  = 3'd3,
    ACT_RUN  = 3'd4
  } action_t;

endpackage

>>> sv/bitmap_allocation_map.sv
// Bitmap allocation map top level: word memory, read-modify-write and scan engine.
// Depends on bam_pkg.
//
// channel | direction | handshake            | payload
// in      | slave     | in_tvalid/in_tready  | tuser action, tdata position, run_length
// out     | master    | out_tvalid/out_tready| tdata ok, in_range, found_member
// cfg     | slave     | cfg_valid/cfg_ready  | cfg_data words_in_use
//
// Set, clear and test: read, write back and result states from accept to out_tvalid.
// Searches scan up to 8 members per step, from the start bit b to the end of each word;
// the 8-lane scan over the registered memory read sets the rate. No-scan cases go from load to result.
// After reset a clearing pass writes zero to all MAP_WORDS words, one per cycle; items
// are taken only after it. A new item is accepted while a result waits on out_tready and
// holds in its result cycle until the output register is free.
module bitmap_allocation_map #(
  parameter int WORD_BITS = bam_pkg::WORD_BITS_DEF,
  parameter int MAP_WORDS = bam_pkg::MAP_WORDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bam_pkg::IN_TDATA_W-1:0]   in_tdata,   // position[15:0], run_length[26:16]
  input  logic [bam_pkg::ACT_W-1:0]        in_tuser,   // action[2:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bam_pkg::OUT_TDATA_W-1:0]  out_tdata,  // ok[0], in_range[1], found_member[17:2]
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bam_pkg::WIU_W-1:0]        cfg_data    // words_in_use[5:0]
);
  import bam_pkg::*;

  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW = $clog2(WORD_BITS);
  localparam int QW = WIU_W;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD, ST_RMW, ST_SCAN, ST_RES
  } state_t;

  state_t                 state_r, state_nxt;
  logic [AW-1:0]          clr_r, clr_nxt;
  logic [WIU_W-1:0]       wiu_r;
  logic [ACT_W-1:0]       act_r, act_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [QW-1:0]          word_r, word_nxt;
  logic [BW-1:0]          bit_r, bit_nxt;
  logic [POS_W-1:0]       mbr_r, mbr_nxt;
  logic [LEN_W-1:0]       run_r, run_nxt;
  logic [POS_W-1:0]       cand_r, cand_nxt;
  logic                   res_ok_r, res_ok_nxt;
  logic                   res_rng_r, res_rng_nxt;
  logic [POS_W-1:0]       res_fnd_r, res_fnd_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [WORD_BITS-1:0]   map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0]   rdata_r;
  logic [AW-1:0]          raddr;
  logic                   wen;
  logic [AW-1:0]          waddr;
  logic [WORD_BITS-1:0]   wdata;

  logic [WIU_W-1:0]       words_eff;
  logic [POS_W-1:0]       cap;
  logic                   pos_in_rng;
  logic [QW-1:0]          quot;
  logic [BW-1:0]          rem;
  logic [WORD_BITS-1:0]   shw;
  logic                   scan_hit;
  logic [POS_W-1:0]       scan_fnd;
  logic [LEN_W-1:0]       scan_run;
  logic [POS_W-1:0]       scan_cand;
  logic                   wend;
  logic                   last_word;
  logic                   cur_bit;
  logic [WORD_BITS-1:0]   bit_mask;
  logic                   out_free;

  assign words_eff  = (32'(wiu_r) > MAP_WORDS) ? WIU_W'(MAP_WORDS) : wiu_r;
  assign cap        = POS_W'(32'(words_eff) * WORD_BITS);
  assign pos_in_rng = pos_r < cap;
  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  // Word index and bit offset of pos_r; only meaningful while pos_r < cap.
  always_comb begin
    logic [POS_W:0] r;
    logic [QW-1:0]  q;
    r = {1'b0, pos_r};
    q = '0;
    for (int k = QW - 1; k >= 0; k--) begin
      if (r >= ((POS_W + 1)'(WORD_BITS) << k)) begin
        r    = r - ((POS_W + 1)'(WORD_BITS) << k);
        q[k] = 1'b1;
      end
    end
    quot = q;
    rem  = BW'(r);
  end

  assign shw       = rdata_r >> bit_r;
  assign wend      = ((BW + 1)'(bit_r) + (BW + 1)'(SCAN_LANES)) >= (BW + 1)'(WORD_BITS);
  assign last_word = ((QW + 1)'(word_r) + (QW + 1)'(1)) >= (QW + 1)'(words_eff);
  assign cur_bit   = rdata_r[bit_r];
  assign bit_mask  = WORD_BITS'(1) << bit_r;

  always_comb begin
    logic [LEN_W-1:0] rv;
    logic [POS_W-1:0] cv;
    logic             hv;
    logic [POS_W-1:0] fv;
    rv = run_r;
    cv = cand_r;
    hv = 1'b0;
    fv = '0;
    for (int i = 0; i < SCAN_LANES; i++) begin
      if (!hv && (((BW + 1)'(bit_r) + (BW + 1)'(i)) < (BW + 1)'(WORD_BITS))) begin
        if (!shw[i]) begin
          if (rv == '0) begin
            cv = mbr_r + POS_W'(i);
          end
          rv = rv + LEN_W'(1);
          if (rv == len_r) begin
            hv = 1'b1;
            fv = cv;
          end
        end else begin
          rv = '0;
        end
      end
    end
    scan_run  = rv;
    scan_cand = cv;
    scan_hit  = hv;
    scan_fnd  = fv;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    act_nxt       = act_r;
    pos_nxt       = pos_r;
    len_nxt       = len_r;
    word_nxt      = word_r;
    bit_nxt       = bit_r;
    mbr_nxt       = mbr_r;
    run_nxt       = run_r;
    cand_nxt      = cand_r;
    res_ok_nxt    = res_ok_r;
    res_rng_nxt   = res_rng_r;
    res_fnd_nxt   = res_fnd_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    raddr         = AW'(word_r);
    wen           = 1'b0;
    waddr         = clr_r;
    wdata         = '0;

    case (state_r)
      ST_CLEAR: begin
        wen     = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MAP_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          act_nxt   = in_tuser;
          pos_nxt   = in_tdata[POS_W-1:0];
          len_nxt   = in_tdata[POS_W+LEN_W-1:POS_W];
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        raddr       = AW'(quot);
        word_nxt    = quot;
        bit_nxt     = rem;
        mbr_nxt     = pos_r;
        run_nxt     = '0;
        cand_nxt    = pos_r;
        res_rng_nxt = pos_in_rng;
        res_ok_nxt  = 1'b0;
        res_fnd_nxt = '0;
        state_nxt   = ST_RES;
        if (act_r == ACT_FFF) begin
          res_fnd_nxt = (pos_r > cap) ? pos_r : cap;
          len_nxt     = LEN_W'(1);
        end
        if (pos_in_rng) begin
          case (act_r)
            ACT_SET, ACT_CLR, ACT_TEST: state_nxt = ST_RMW;
            ACT_FFF:                    state_nxt = ST_SCAN;
            ACT_RUN: begin
              if (len_r != '0) begin
                state_nxt = ST_SCAN;
              end
            end
            default: state_nxt = ST_RES;
          endcase
        end
      end
      ST_RMW: begin
        waddr = AW'(word_r);
        case (act_r)
          ACT_SET: begin
            wen        = 1'b1;
            wdata      = rdata_r | bit_mask;
            res_ok_nxt = !cur_bit;
          end
          ACT_CLR: begin
            wen        = 1'b1;
            wdata      = rdata_r & ~bit_mask;
            res_ok_nxt = cur_bit;
          end
          default: res_ok_nxt = cur_bit;
        endcase
        state_nxt = ST_RES;
      end
      ST_SCAN: begin
        run_nxt  = scan_run;
        cand_nxt = scan_cand;
        if (scan_hit) begin
          res_ok_nxt  = 1'b1;
          res_fnd_nxt = scan_fnd;
          state_nxt   = ST_RES;
        end else if (wend) begin
          bit_nxt  = '0;
          mbr_nxt  = mbr_r + POS_W'(WORD_BITS) - POS_W'(bit_r);
          word_nxt = word_r + QW'(1);
          raddr    = AW'(word_r + QW'(1));
          if (last_word) begin
            state_nxt = ST_RES;
          end
        end else begin
          bit_nxt = bit_r + BW'(SCAN_LANES);
          mbr_nxt = mbr_r + POS_W'(SCAN_LANES);
        end
      end
      ST_RES: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_TDATA_W'({res_fnd_r, res_rng_r, res_ok_r});
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      map_mem[waddr] <= wdata;
    end
    rdata_r <= map_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      wiu_r       <= WIU_W'(WIU_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        wiu_r <= cfg_data;
      end
    end
    act_r      <= act_nxt;
    pos_r      <= pos_nxt;
    len_r      <= len_nxt;
    word_r     <= word_nxt;
    bit_r      <= bit_nxt;
    mbr_r      <= mbr_nxt;
    run_r      <= run_nxt;
    cand_r     <= cand_nxt;
    res_ok_r   <= res_ok_nxt;
    res_rng_r  <= res_rng_nxt;
    res_fnd_r  <= res_fnd_nxt;
    out_data_r <= out_data_nxt;
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_tready)
    else $error("item accepted during clearing pass");

  a_scan_word_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ((QW + 1)'(word_r) < (QW + 1)'(words_eff)))
    else $error("scan past words in use");

  a_found_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RES && res_ok_r && (act_r == ACT_FFF || act_r == ACT_RUN))
      |-> (res_fnd_r < cap))
    else $error("found member beyond capacity");

  a_ok_needs_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RES && res_ok_r) |-> res_rng_r)
    else $error("ok result for out of range position");

endmodule

>>> tb/bitmap_allocation_map_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_allocation_map: streams set, clear, test and search
// requests across several map sizes, predicts each result and checks it. Depends on bam_pkg.
module bitmap_allocation_map_test;
  import bam_pkg::*;

  localparam int MEMBER_BITS  = WORD_BITS_DEF;
  localparam int NUM_WORDS    = MAP_WORDS_DEF;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [POS_W-1:0] position;
    logic [LEN_W-1:0] run_length;
  } request_t;

  typedef struct packed {
    logic             ok;
    logic             in_range;
    logic [POS_W-1:0] found_member;
  } response_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [ACT_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [WIU_W-1:0]       cfg_data = '0;

  request_t                 request_q[$];
  response_t                response_q[$];
  request_t                 driven_req;
  logic [MEMBER_BITS-1:0]   map_model [NUM_WORDS] = '{default: '0};
  logic [WIU_W-1:0]         words_in_use_model = WIU_W'(WIU_RESET);
  int unsigned              gen_cap = NUM_WORDS * MEMBER_BITS;
  int unsigned              tx_idle_pct = 0;
  int unsigned              rx_idle_pct = 0;
  int                       error_count = 0;
  int                       cycle_count = 0;

  bitmap_allocation_map DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // position[15:0], run_length[26:16]
    .in_tuser  (in_tuser),   // action[2:0]
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // ok[0], in_range[1], found_member[17:2]
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)    // words_in_use[5:0]
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned map_capacity(logic [WIU_W-1:0] wiu);
    return ((wiu > NUM_WORDS) ? NUM_WORDS : int'(wiu)) * MEMBER_BITS;
  endfunction

  function automatic logic member_bit(int unsigned m);
    return map_model[m / MEMBER_BITS][m % MEMBER_BITS];
  endfunction

  function automatic response_t predict_map_response(request_t req);
    int unsigned cap;
    int unsigned m;
    int unsigned run_len;
    response_t   rsp;
    cap = map_capacity(words_in_use_model);
    rsp = '0;
    rsp.in_range = (req.position < cap);
    case (req.action)
      ACT_SET, ACT_CLR: begin
        if (rsp.in_range) begin
          rsp.ok = (member_bit(req.position) != (req.action == ACT_SET));
          map_model[req.position / MEMBER_BITS][req.position % MEMBER_BITS] =
            (req.action == ACT_SET);
        end
      end
      ACT_TEST: begin
        if (rsp.in_range) rsp.ok = member_bit(req.position);
      end
      ACT_FFF: begin
        rsp.found_member = (req.position > cap) ? req.position : POS_W'(cap);
        for (m = req.position; m < cap && !rsp.ok; m++) begin
          if (!member_bit(m)) begin
            rsp.ok = 1'b1;
            rsp.found_member = POS_W'(m);
          end
        end
      end
      ACT_RUN: begin
        run_len = 0;
        for (m = req.position; m < cap && req.run_length != 0 && !rsp.ok; m++) begin
          if (member_bit(m)) begin
            run_len = 0;
          end else begin
            run_len++;
            if (run_len == req.run_length) begin
              rsp.ok = 1'b1;
              rsp.found_member = POS_W'(m + 1 - run_len);
            end
          end
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic void queue_request(logic [ACT_W-1:0] act, int unsigned pos,
                                        int unsigned len);
    request_t req;
    req.action     = act;
    req.position   = POS_W'(pos);
    req.run_length = LEN_W'(len);
    request_q.push_back(req);
  endfunction

  function automatic int unsigned pick_position();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 9) return $urandom_range(16'hFFFF);
    if (r >= 7) return $urandom_range(gen_cap + 40, (gen_cap > 40) ? gen_cap - 40 : 0);
    return $urandom_range((gen_cap > 0) ? gen_cap - 1 : 0, 0);
  endfunction

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 9) return $urandom_range(2047);
    if (r == 8) return $urandom_range(1024, 64);
    return $urandom_range(24);
  endfunction

  function automatic void queue_random_items(int n);
    int          count;
    int unsigned r;
    int unsigned base;
    int unsigned span;
    count = 0;
    while (count < n) begin
      r = $urandom_range(99);
      if (r < 10) begin
        base = pick_position();
        span = $urandom_range(20, 2);
        for (int j = 0; j < span; j++) queue_request(ACT_SET, base + j, pick_length());
        queue_request(ACT_FFF, base, pick_length());
        queue_request(ACT_RUN, (base > span) ? base - span : 0, $urandom_range(span + 4, 1));
        count += span + 2;
      end else begin
        if (r < 35)      queue_request(ACT_SET, pick_position(), pick_length());
        else if (r < 47) queue_request(ACT_CLR, pick_position(), pick_length());
        else if (r < 60) queue_request(ACT_TEST, pick_position(), pick_length());
        else if (r < 72) queue_request(ACT_FFF, pick_position(), pick_length());
        else if (r < 86) queue_request(ACT_RUN, pick_position(), pick_length());
        else if (r < 92) queue_request(ACT_W'($urandom_range(7, int'(ACT_RUN) + 1)),
                                       pick_position(), pick_length());
        else             queue_request(ACT_W'($urandom_range(7)), $urandom_range(16'hFFFF),
                                       $urandom_range(2047));
        count++;
      end
    end
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (request_q.size() != 0 || in_tvalid || response_q.size() != 0);
  endtask

  task automatic write_words_in_use(logic [WIU_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    words_in_use_model = value;
    gen_cap = map_capacity(value);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [WIU_W-1:0] wiu, int n, int unsigned tx_pct,
                           int unsigned rx_pct);
    wait_idle();
    write_words_in_use(wiu);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    queue_random_items(n);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) response_q.push_back(predict_map_response(driven_req));
      if (!in_tvalid || in_tready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          driven_req = request_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= driven_req.action;
          in_tdata  <= {{(IN_TDATA_W - POS_W - LEN_W){1'b0}},
                        driven_req.run_length, driven_req.position};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    response_t expected;
    response_t actual;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        actual.ok           = out_tdata[0];
        actual.in_range     = out_tdata[1];
        actual.found_member = out_tdata[17:2];
        if (response_q.size() == 0) begin
          $error("unexpected result: tdata %h", out_tdata);
          error_count++;
        end else begin
          expected = response_q.pop_front();
          if (actual.ok !== expected.ok) begin
            $error("ok: expected %0d, got %0d", expected.ok, actual.ok);
            error_count++;
          end
          if (actual.in_range !== expected.in_range) begin
            $error("in_range: expected %0d, got %0d", expected.in_range, actual.in_range);
            error_count++;
          end
          if (actual.found_member !== expected.found_member) begin
            $error("found_member: expected %0d, got %0d",
                   expected.found_member, actual.found_member);
            error_count++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[bitmap_allocation_map] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 31;
    rx_idle_pct = 71;

    queue_request(ACT_SET, 0, 0);
    queue_request(ACT_SET, 0, 2047);
    queue_request(ACT_TEST, 0, 0);
    queue_request(ACT_SET, 31, 0);
    queue_request(ACT_TEST, 31, 1024);
    queue_request(ACT_SET, 32, 0);
    queue_request(ACT_SET, 1023, 0);
    queue_request(ACT_TEST, 1023, 0);
    queue_request(ACT_SET, 1024, 0);
    queue_request(ACT_TEST, 16'hFFFF, 2047);
    queue_request(ACT_CLR, 1023, 0);
    queue_request(ACT_CLR, 1023, 0);
    queue_request(ACT_CLR, 16'hFFFF, 0);
    queue_request(ACT_FFF, 0, 0);
    queue_request(ACT_FFF, 1020, 0);
    queue_request(ACT_FFF, 1024, 0);
    queue_request(ACT_FFF, 16'hFFFF, 2047);
    queue_request(ACT_RUN, 0, 0);
    queue_request(ACT_RUN, 0, 30);
    queue_request(ACT_RUN, 0, 1024);
    queue_request(ACT_RUN, 0, 2047);
    queue_request(ACT_RUN, 1023, 1);
    queue_request(ACT_RUN, 16'hFFFF, 1);
    queue_request(ACT_W'(int'(ACT_RUN) + 1), 16'hFFFF, 2047);
    queue_request(ACT_W'(7), 0, 0);
    queue_random_items(60);

    run_phase(WIU_W'(0), 40, 31, 71);
    run_phase(WIU_W'(63), 80, 31, 71);
    run_phase(WIU_W'(1), 60, 71, 31);
    run_phase(WIU_W'($urandom_range(31, 2)), 80, 71, 31);
    run_phase(WIU_W'(33), 80, 0, 0);
    run_phase(WIU_W'(WIU_RESET), 70, 0, 0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && response_q.size() == 0) begin
      $display("[bitmap_allocation_map] OK");
    end else begin
      $display("[bitmap_allocation_map] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/bam_pkg.sv
sv/bitmap_allocation_map.sv
tb/bitmap_allocation_map_test.sv
